>>> hdl/swf_pkg.sv
// ============================================================================
// swf_pkg
// Shared types, fixed-point constants and the quarter-wave sine table entry
// function for the swing foot trajectory block.
// ============================================================================
package swf_pkg;

    // Field widths and fixed-point formats
    localparam int PHASE_FRAC_BITS = 16;
    localparam int PHASE_W         = PHASE_FRAC_BITS + 1;
    localparam int POS_W           = 24;
    localparam int CLEAR_W         = 20;
    localparam int SINE_N          = 256;
    localparam int SINE_IDX_W      = $clog2(SINE_N) + 1;
    localparam int SINE_W          = 31;
    localparam int IDX_LSB         = PHASE_FRAC_BITS - 1 - $clog2(SINE_N);

    localparam logic [PHASE_W-1:0] PH_ONE  = PHASE_W'(1) << PHASE_FRAC_BITS;
    localparam logic [PHASE_W-1:0] PH_HALF = PH_ONE >> 1;

    localparam logic [CLEAR_W-1:0] CLEAR_RESET = 20'd150000;

    // Shaped phase numerators before the divide by five
    localparam logic [18:0] UP_BASE   = 19'd196610;   // 4*ONE - ONE + 2
    localparam logic [32:0] LOW_ROUND = 33'd40960;    // half of 5 << 14
    localparam logic [18:0] RECIP5    = 19'd419431;   // ceil(2^21 / 5)
    localparam int          RECIP5_SH = 21;

    localparam logic signed [31:0] POS_MAX = 32'sd8388607;
    localparam logic signed [31:0] POS_MIN = -32'sd8388608;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned Q30_ONE     = 64'd1073741824;

    typedef struct packed {
        logic        [PHASE_W-1:0] swing_phase;
        logic signed [POS_W-1:0]   start_x;
        logic signed [POS_W-1:0]   start_y;
        logic signed [POS_W-1:0]   start_z;
        logic signed [POS_W-1:0]   target_x;
        logic signed [POS_W-1:0]   target_y;
        logic signed [POS_W-1:0]   target_z;
    } swf_in_t;

    typedef struct packed {
        logic signed [POS_W-1:0] foot_x;
        logic signed [POS_W-1:0] foot_y;
        logic signed [POS_W-1:0] foot_z;
    } swf_out_t;

    // sin of entry i in Q30, Taylor series to the x^15 term, truncating terms
    function automatic logic [SINE_W-1:0] sine_entry(input int unsigned i);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned pos;
        longint unsigned neg;
        longint unsigned v;
        x    = (HALF_PI_Q30 * 64'(i) + 64'(SINE_N / 2)) / SINE_N;
        x2   = (x * x) >> 30;
        pos  = x;
        term = ((x * x2) >> 30) / 6;
        neg  = term;
        term = ((term * x2) >> 30) / 20;
        pos  = pos + term;
        term = ((term * x2) >> 30) / 42;
        neg  = neg + term;
        term = ((term * x2) >> 30) / 72;
        pos  = pos + term;
        term = ((term * x2) >> 30) / 110;
        neg  = neg + term;
        term = ((term * x2) >> 30) / 156;
        pos  = pos + term;
        term = ((term * x2) >> 30) / 210;
        neg  = neg + term;
        v    = (pos > neg) ? (pos - neg) : 64'd0;
        if (v > Q30_ONE)
        begin
            v = Q30_ONE;
        end
        return v[SINE_W-1:0];
    endfunction

    // Clamp a wide signed value into the position range
    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [31:0] v);
        logic signed [31:0] c;
        c = v;
        if (v > POS_MAX)
        begin
            c = POS_MAX;
        end
        else if (v < POS_MIN)
        begin
            c = POS_MIN;
        end
        return c[POS_W-1:0];
    endfunction

endpackage

>>> hdl/swing_foot_trajectory_top.sv
// An accepted input word reaches the output as its foot word from the stage 7 register.
// Throughput: one word per cycle; the 7-stage pipeline takes a new word every
// cycle while the output is taken, and a stalled stage holds its word.
// Reset (rst_n low, asynchronous): all stage valid bits clear, the pipeline is
// empty, and the clearance register returns to 150000 um. No clearing pass.
// ============================================================================
// swing_foot_trajectory_top
// Swing foot trajectory point generator: reshapes the swing phase through a
// sine table (lower half) or a linear ramp (upper half), blends x and y
// linearly and runs z along a parabola lifted by the programmed clearance.
// ============================================================================
module swing_foot_trajectory_top (
    input  logic               clk,
    input  logic               rst_n,
    // input words
    input  logic               point_valid,
    output logic               point_ready,
    input  swf_pkg::swf_in_t   point,
    // output words
    output logic               foot_valid,
    input  logic               foot_ready,
    output swf_pkg::swf_out_t  foot,
    // clearance register write
    input  logic               cfg_wr_en,
    input  logic [19:0]        cfg_wr_data
);
    import swf_pkg::*;

    localparam int NS = 7;

    // ------------------------------------------------------------------------
    // Pipeline control. A stage can load when it is empty or when the stage
    // after it is loading too; the last stage drains into the consumer.
    // ------------------------------------------------------------------------
    logic [NS:1] vld_reg;
    logic [NS:1] vld_next;
    logic [NS:1] stg_rdy;

    always_comb
    begin
        stg_rdy[NS] = !vld_reg[NS] || foot_ready;
        for (int k = NS - 1; k >= 1; k--)
        begin
            stg_rdy[k] = !vld_reg[k] || stg_rdy[k+1];
        end
        vld_next[1] = stg_rdy[1] ? point_valid : vld_reg[1];
        for (int k = 2; k <= NS; k++)
        begin
            vld_next[k] = stg_rdy[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign point_ready = stg_rdy[1];
    assign foot_valid  = vld_reg[NS];

    // ------------------------------------------------------------------------
    // Configuration: foot lift clearance; the user writes it only while the block is idle (not enforced here).
    // ------------------------------------------------------------------------
    logic [CLEAR_W-1:0] clear_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_reg <= CLEAR_RESET;
        end
        else if (cfg_wr_en)
        begin
            clear_reg <= cfg_wr_data;
        end
    end

    // ------------------------------------------------------------------------
    // Quarter-wave sine table, one constant per entry.
    // ------------------------------------------------------------------------
    logic [SINE_W-1:0] sine_rom [0:SINE_N];

    for (genvar g = 0; g <= SINE_N; g++)
    begin : g_sine
        localparam logic [SINE_W-1:0] ENTRY = sine_entry(g);
        assign sine_rom[g] = ENTRY;
    end

    // ------------------------------------------------------------------------
    // Stage 1: clamp the phase, pick the branch, read both sine table taps,
    // form coordinate deltas and the parabola offsets.
    // ------------------------------------------------------------------------
    logic [PHASE_W-1:0]        p_clamp;
    logic                      lower_next;
    logic [SINE_IDX_W-1:0]     idx;
    logic [SINE_IDX_W-1:0]     idx_hi;
    logic [PHASE_FRAC_BITS-1:0] frac_next;
    logic [18:0]               upnum_next;
    logic signed [POS_W-1:0]   zmax;
    logic signed [POS_W+1:0]   mid;
    logic signed [POS_W:0]     dx_next;
    logic signed [POS_W:0]     dy_next;
    logic signed [POS_W+1:0]   d1_next;
    logic signed [POS_W:0]     d2_next;

    always_comb
    begin
        p_clamp    = (point.swing_phase > PH_ONE) ? PH_ONE : point.swing_phase;
        lower_next = (p_clamp <= PH_HALF);
        // at exactly one half the index reaches the last table entry
        idx        = lower_next ? p_clamp[PHASE_FRAC_BITS-1:IDX_LSB] : '0;
        idx_hi     = idx[SINE_IDX_W-1] ? idx : idx + SINE_IDX_W'(1);
        frac_next  = {p_clamp[IDX_LSB-1:0], (PHASE_FRAC_BITS - IDX_LSB)'(0)};
        upnum_next = UP_BASE + 19'({p_clamp, 1'b0});

        dx_next = (POS_W+1)'(point.target_x) - (POS_W+1)'(point.start_x);
        dy_next = (POS_W+1)'(point.target_y) - (POS_W+1)'(point.start_y);
        d2_next = (POS_W+1)'(point.target_z) - (POS_W+1)'(point.start_z);

        // peak height: higher endpoint plus clearance
        zmax    = (point.start_z > point.target_z) ? point.start_z : point.target_z;
        mid     = (POS_W+2)'(zmax) + $signed({6'b0, clear_reg});
        d1_next = mid - (POS_W+2)'(point.start_z);
    end

    logic [SINE_W-1:0]          lo_s1_reg;
    logic [SINE_W-1:0]          hi_s1_reg;
    logic [PHASE_FRAC_BITS-1:0] frac_s1_reg;
    logic                       lower_s1_reg;
    logic [18:0]                upnum_s1_reg;
    logic signed [POS_W:0]      dx_s1_reg;
    logic signed [POS_W:0]      dy_s1_reg;
    logic signed [POS_W+1:0]    d1_s1_reg;
    logic signed [POS_W:0]      d2_s1_reg;
    logic signed [POS_W-1:0]    sx_s1_reg;
    logic signed [POS_W-1:0]    sy_s1_reg;
    logic signed [POS_W-1:0]    sz_s1_reg;

    always_ff @(posedge clk)
    begin
        if (stg_rdy[1])
        begin
            lo_s1_reg    <= sine_rom[idx];
            hi_s1_reg    <= sine_rom[idx_hi];
            frac_s1_reg  <= frac_next;
            lower_s1_reg <= lower_next;
            upnum_s1_reg <= upnum_next;
            dx_s1_reg    <= dx_next;
            dy_s1_reg    <= dy_next;
            d1_s1_reg    <= d1_next;
            d2_s1_reg    <= d2_next;
            sx_s1_reg    <= point.start_x;
            sy_s1_reg    <= point.start_y;
            sz_s1_reg    <= point.start_z;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 2: linear interpolation between the two table taps.
    // ------------------------------------------------------------------------
    logic [SINE_W-1:0]            sdiff;
    logic [SINE_W+PHASE_FRAC_BITS-1:0] sprod;
    logic [SINE_W-1:0]            sq_next;

    always_comb
    begin
        sdiff   = (hi_s1_reg > lo_s1_reg) ? (hi_s1_reg - lo_s1_reg) : '0;
        sprod   = sdiff * frac_s1_reg;
        sq_next = lo_s1_reg + sprod[SINE_W+PHASE_FRAC_BITS-1:PHASE_FRAC_BITS];
    end

    logic [SINE_W-1:0]       sq_s2_reg;
    logic                    lower_s2_reg;
    logic [18:0]             upnum_s2_reg;
    logic signed [POS_W:0]   dx_s2_reg;
    logic signed [POS_W:0]   dy_s2_reg;
    logic signed [POS_W+1:0] d1_s2_reg;
    logic signed [POS_W:0]   d2_s2_reg;
    logic signed [POS_W-1:0] sx_s2_reg;
    logic signed [POS_W-1:0] sy_s2_reg;
    logic signed [POS_W-1:0] sz_s2_reg;

    always_ff @(posedge clk)
    begin
        if (stg_rdy[2])
        begin
            sq_s2_reg    <= sq_next;
            lower_s2_reg <= lower_s1_reg;
            upnum_s2_reg <= upnum_s1_reg;
            dx_s2_reg    <= dx_s1_reg;
            dy_s2_reg    <= dy_s1_reg;
            d1_s2_reg    <= d1_s1_reg;
            d2_s2_reg    <= d2_s1_reg;
            sx_s2_reg    <= sx_s1_reg;
            sy_s2_reg    <= sy_s1_reg;
            sz_s2_reg    <= sz_s1_reg;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 3: shaped phase s = numerator / 5, by reciprocal multiply.
    // The lower numerator is (4*sin + 40960) >> 14, which folds the 5 << 14
    // denominator into a shift and the same divide by five.
    // ------------------------------------------------------------------------
    logic [32:0] lnum;
    logic [18:0] num5;
    logic [37:0] rprod;
    logic [PHASE_W-1:0] s_next;

    always_comb
    begin
        lnum   = {sq_s2_reg, 2'b00} + LOW_ROUND;
        num5   = lower_s2_reg ? lnum[32:14] : upnum_s2_reg;
        rprod  = num5 * RECIP5;
        s_next = rprod[RECIP5_SH+PHASE_W-1:RECIP5_SH];
    end

    logic [PHASE_W-1:0]      s_s3_reg;
    logic signed [POS_W:0]   dx_s3_reg;
    logic signed [POS_W:0]   dy_s3_reg;
    logic signed [POS_W+1:0] d1_s3_reg;
    logic signed [POS_W:0]   d2_s3_reg;
    logic signed [POS_W-1:0] sx_s3_reg;
    logic signed [POS_W-1:0] sy_s3_reg;
    logic signed [POS_W-1:0] sz_s3_reg;

    always_ff @(posedge clk)
    begin
        if (stg_rdy[3])
        begin
            s_s3_reg  <= s_next;
            dx_s3_reg <= dx_s2_reg;
            dy_s3_reg <= dy_s2_reg;
            d1_s3_reg <= d1_s2_reg;
            d2_s3_reg <= d2_s2_reg;
            sx_s3_reg <= sx_s2_reg;
            sy_s3_reg <= sy_s2_reg;
            sz_s3_reg <= sz_s2_reg;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 4: raw products for the parabola weights and the x/y blend.
    // ------------------------------------------------------------------------
    logic [PHASE_W-1:0]        one_minus_s;
    logic signed [PHASE_W+1:0] s2m;
    logic signed [PHASE_W:0]   s_sgn;
    logic [2*PHASE_W-1:0]      pw1_next;
    logic signed [2*PHASE_W+2:0] pw2_next;
    logic signed [POS_W+PHASE_W+1:0] pbx_next;
    logic signed [POS_W+PHASE_W+1:0] pby_next;

    always_comb
    begin
        s_sgn       = $signed({1'b0, s_s3_reg});
        one_minus_s = PH_ONE - s_s3_reg;
        s2m         = $signed({1'b0, s_s3_reg, 1'b0}) - $signed({2'b00, PH_ONE});
        pw1_next    = s_s3_reg * one_minus_s;
        pw2_next    = s_sgn * s2m;
        pbx_next    = dx_s3_reg * s_sgn;
        pby_next    = dy_s3_reg * s_sgn;
    end

    logic [2*PHASE_W-1:0]            pw1_s4_reg;
    logic signed [2*PHASE_W+2:0]     pw2_s4_reg;
    logic signed [POS_W+PHASE_W+1:0] pbx_s4_reg;
    logic signed [POS_W+PHASE_W+1:0] pby_s4_reg;
    logic signed [POS_W+1:0]         d1_s4_reg;
    logic signed [POS_W:0]           d2_s4_reg;
    logic signed [POS_W-1:0]         sx_s4_reg;
    logic signed [POS_W-1:0]         sy_s4_reg;
    logic signed [POS_W-1:0]         sz_s4_reg;

    always_ff @(posedge clk)
    begin
        if (stg_rdy[4])
        begin
            pw1_s4_reg <= pw1_next;
            pw2_s4_reg <= pw2_next;
            pbx_s4_reg <= pbx_next;
            pby_s4_reg <= pby_next;
            d1_s4_reg  <= d1_s3_reg;
            d2_s4_reg  <= d2_s3_reg;
            sx_s4_reg  <= sx_s3_reg;
            sy_s4_reg  <= sy_s3_reg;
            sz_s4_reg  <= sz_s3_reg;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 5: round the weights (half up, arithmetic shift) and finish the
    // x/y blend with saturation.
    // ------------------------------------------------------------------------
    localparam logic [2*PHASE_W+2:0] HALF_LSB = (2*PHASE_W+3)'(1) << (PHASE_FRAC_BITS - 1);

    logic [2*PHASE_W+2:0]        w1_sum;
    logic signed [2*PHASE_W+2:0] w2_sum;
    logic signed [POS_W+PHASE_W+1:0] bx_sum;
    logic signed [POS_W+PHASE_W+1:0] by_sum;
    logic signed [POS_W+2:0]     fx_full;
    logic signed [POS_W+2:0]     fy_full;
    logic [PHASE_W-1:0]          w1_next;
    logic signed [PHASE_W:0]     w2_next;
    logic signed [POS_W-1:0]     fx_next;
    logic signed [POS_W-1:0]     fy_next;

    always_comb
    begin
        w1_sum  = {1'b0, pw1_s4_reg, 2'b00} + HALF_LSB;
        w2_sum  = pw2_s4_reg + $signed(HALF_LSB);
        w1_next = w1_sum[PHASE_FRAC_BITS+PHASE_W-1:PHASE_FRAC_BITS];
        w2_next = w2_sum[PHASE_FRAC_BITS+PHASE_W:PHASE_FRAC_BITS];

        bx_sum  = pbx_s4_reg + (POS_W+PHASE_W+2)'($signed(HALF_LSB));
        by_sum  = pby_s4_reg + (POS_W+PHASE_W+2)'($signed(HALF_LSB));
        fx_full = (POS_W+3)'(sx_s4_reg)
                + (POS_W+3)'(bx_sum[POS_W+PHASE_W+1:PHASE_FRAC_BITS]);
        fy_full = (POS_W+3)'(sy_s4_reg)
                + (POS_W+3)'(by_sum[POS_W+PHASE_W+1:PHASE_FRAC_BITS]);
        fx_next = sat_pos(32'(fx_full));
        fy_next = sat_pos(32'(fy_full));
    end

    logic [PHASE_W-1:0]      w1_s5_reg;
    logic signed [PHASE_W:0] w2_s5_reg;
    logic signed [POS_W+1:0] d1_s5_reg;
    logic signed [POS_W:0]   d2_s5_reg;
    logic signed [POS_W-1:0] sz_s5_reg;
    logic signed [POS_W-1:0] fx_s5_reg;
    logic signed [POS_W-1:0] fy_s5_reg;

    always_ff @(posedge clk)
    begin
        if (stg_rdy[5])
        begin
            w1_s5_reg <= w1_next;
            w2_s5_reg <= w2_next;
            d1_s5_reg <= d1_s4_reg;
            d2_s5_reg <= d2_s4_reg;
            sz_s5_reg <= sz_s4_reg;
            fx_s5_reg <= fx_next;
            fy_s5_reg <= fy_next;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 6: parabola products d1*w1 and d2*w2.
    // ------------------------------------------------------------------------
    localparam int PZ_W = POS_W + PHASE_W + 3;

    logic signed [PZ_W-1:0] pz1_next;
    logic signed [PZ_W-1:0] pz2_next;

    always_comb
    begin
        pz1_next = d1_s5_reg * $signed({1'b0, w1_s5_reg});
        pz2_next = d2_s5_reg * w2_s5_reg;
    end

    logic signed [PZ_W-1:0]  pz1_s6_reg;
    logic signed [PZ_W-1:0]  pz2_s6_reg;
    logic signed [POS_W-1:0] sz_s6_reg;
    logic signed [POS_W-1:0] fx_s6_reg;
    logic signed [POS_W-1:0] fy_s6_reg;

    always_ff @(posedge clk)
    begin
        if (stg_rdy[6])
        begin
            pz1_s6_reg <= pz1_next;
            pz2_s6_reg <= pz2_next;
            sz_s6_reg  <= sz_s5_reg;
            fx_s6_reg  <= fx_s5_reg;
            fy_s6_reg  <= fy_s5_reg;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 7 (output register): sum, round, add start height, saturate.
    // ------------------------------------------------------------------------
    logic signed [PZ_W:0]    zsum;
    logic signed [PZ_W-PHASE_FRAC_BITS:0] zround;
    logic signed [31:0]      z_full;
    swf_out_t                foot_next;
    swf_out_t                foot_reg;

    always_comb
    begin
        zsum   = (PZ_W+1)'(pz1_s6_reg) + (PZ_W+1)'(pz2_s6_reg)
               + (PZ_W+1)'($signed(HALF_LSB));
        zround = zsum[PZ_W:PHASE_FRAC_BITS];
        z_full = 32'(zround) + 32'(sz_s6_reg);
        foot_next.foot_x = fx_s6_reg;
        foot_next.foot_y = fy_s6_reg;
        foot_next.foot_z = sat_pos(z_full);
    end

    always_ff @(posedge clk)
    begin
        if (stg_rdy[7])
        begin
            foot_reg <= foot_next;
        end
    end

    assign foot = foot_reg;

endmodule
